/* design/tool_height_dilation_core_assert.svh */
// ----------------------------------------------------------------------------
// Tool height dilation assertion macros
// Clocked concurrent checks with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef TOOL_HEIGHT_DILATION_CORE_ASSERT_SVH
`define TOOL_HEIGHT_DILATION_CORE_ASSERT_SVH

// property holds at every edge out of reset
`define THD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// pre at one edge implies post at the next
`define THD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/thd_pkg.sv */
// ----------------------------------------------------------------------------
// Tool height dilation package
// Shared constants, configuration layout and control types.
// ----------------------------------------------------------------------------
package thd_pkg;

  localparam int MAX_COLS_DEF   = 256;
  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_WINDOW_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int HEIGHT_W   = 16;
  localparam int TOOL_W     = 15;
  localparam int RAD_W      = 5;

  localparam logic [1:0] DRAIN_CYC = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH    = 3'd0,
    CFG_MAP_HEIGHT   = 3'd1,
    CFG_WINDOW_CELLS = 3'd2,
    CFG_DISK_RADIUS  = 3'd3,
    CFG_DROP_DEPTH   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0]        map_width;
    logic [8:0]        map_height;
    logic [5:0]        window_cells;
    logic [RAD_W-1:0]  disk_radius;
    logic [14:0]       drop_depth;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    map_width:    9'd256,
    map_height:   9'd256,
    window_cells: 6'd7,
    disk_radius:  5'd3,
    drop_depth:   15'd2560
  };

  typedef struct packed {
    logic clear;
    logic hit;
  } acc_ctl_t;

endpackage

/* design/thd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module thd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/thd_seq.sv */
// ----------------------------------------------------------------------------
// Window walker
// Steps through the window one position a cycle and issues map reads.
// ----------------------------------------------------------------------------
module thd_seq import thd_pkg::*; #(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1),
  localparam int CRD_W     = $clog2(MAX_COLS + MAX_ROWS + 256 + 2 * MAX_WINDOW) + 1,
  localparam int ADDR_W    = $clog2(MAX_COLS * MAX_ROWS),
  localparam int COL_W     = $clog2(MAX_COLS),
  localparam int ROW_W     = $clog2(MAX_ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [7:0]        col,
  input  logic [7:0]        row,
  input  logic [CNT_W-1:0]  n,
  input  logic [CRD_W-1:0]  w_eff,
  input  logic [CRD_W-1:0]  h_eff,
  output acc_ctl_t          ctl,
  output logic [CNT_W-1:0]  tx,
  output logic [CNT_W-1:0]  ty,
  output logic [ADDR_W-1:0] raddr,
  output logic              last
);

  logic             active_r, active_nxt;
  logic [CNT_W-1:0] tx_r, tx_nxt;
  logic [CNT_W-1:0] ty_r, ty_nxt;
  logic [7:0]       col_r, col_nxt;
  logic [7:0]       row_r, row_nxt;
  logic [CNT_W-1:0] c;
  logic [CNT_W-1:0] n_m1;
  logic [CRD_W-1:0] nx, ny;
  logic             in_x, in_y, tx_end, ty_end;

  always_comb begin
    c      = n >> 1;
    n_m1   = n - CNT_W'(1);
    nx     = CRD_W'(col_r) - CRD_W'(tx_r) + CRD_W'(c);
    ny     = CRD_W'(row_r) - CRD_W'(ty_r) + CRD_W'(c);
    in_x   = !nx[CRD_W-1] && (nx < w_eff);
    in_y   = !ny[CRD_W-1] && (ny < h_eff);
    tx_end = (tx_r == n_m1);
    ty_end = (ty_r == n_m1);
    raddr  = ADDR_W'(ny[ROW_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(nx[COL_W-1:0]);

    ctl.clear = start;
    ctl.hit   = active_r && in_x && in_y;
    last      = active_r && tx_end && ty_end;

    active_nxt = active_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (start) begin
      active_nxt = 1'b1;
      tx_nxt     = '0;
      ty_nxt     = '0;
      col_nxt    = col;
      row_nxt    = row;
    end else if (active_r) begin
      if (ty_end) begin
        ty_nxt = '0;
        if (tx_end) begin
          active_nxt = 1'b0;
        end else begin
          tx_nxt = tx_r + CNT_W'(1);
        end
      end else begin
        ty_nxt = ty_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_r  <= tx_nxt;
    ty_r  <= ty_nxt;
    col_r <= col_nxt;
    row_r <= row_nxt;
  end

  assign tx = tx_r;
  assign ty = ty_r;

endmodule

/* design/thd_acc.sv */
// ----------------------------------------------------------------------------
// Dilation accumulator
// Disk test, drop offset and running maximum, one sample a cycle.
// ----------------------------------------------------------------------------
module thd_acc import thd_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1),
  localparam int DX_W      = ((CNT_W > RAD_W) ? CNT_W : RAD_W) + 1,
  localparam int SQ_W      = 2 * DX_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  acc_ctl_t                   ctl,
  input  logic [CNT_W-1:0]           tx,
  input  logic [CNT_W-1:0]           ty,
  input  logic [RAD_W-1:0]           disk_radius,
  input  logic [14:0]                drop_depth,
  input  logic [HEIGHT_W-1:0]        rdata,
  output logic signed [HEIGHT_W-1:0] best
);

  // stage 1: read data arrives, disk test
  logic                 p1_hit_r;
  logic signed [DX_W-1:0] p1_dx_r, p1_dy_r;
  // stage 2: offset and compare
  logic                 p2_hit_r;
  logic                 p2_out_r;
  logic [HEIGHT_W-1:0]  p2_h_r;
  logic signed [HEIGHT_W-1:0] best_r, best_nxt;

  logic signed [SQ_W-1:0] dx_sq, dy_sq;
  logic [SQ_W:0]          d_sum;
  logic [2*RAD_W-1:0]     r_sq;
  logic                   outside;
  logic signed [HEIGHT_W:0] v;

  always_comb begin
    dx_sq   = SQ_W'(p1_dx_r) * SQ_W'(p1_dx_r);
    dy_sq   = SQ_W'(p1_dy_r) * SQ_W'(p1_dy_r);
    r_sq    = (2*RAD_W)'(disk_radius) * (2*RAD_W)'(disk_radius);
    d_sum   = (SQ_W+1)'($unsigned(dx_sq)) + (SQ_W+1)'($unsigned(dy_sq));
    outside = d_sum > (SQ_W+1)'(r_sq);

    v = (HEIGHT_W+1)'($signed(p2_h_r)) -
        (p2_out_r ? (HEIGHT_W+1)'(drop_depth) : '0);
    best_nxt = best_r;
    if (ctl.clear) begin
      best_nxt = '0;
    end else if (p2_hit_r && (v > (HEIGHT_W+1)'(best_r))) begin
      best_nxt = v[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_hit_r <= 1'b0;
      p2_hit_r <= 1'b0;
      best_r   <= '0;
    end else begin
      p1_hit_r <= ctl.hit;
      p2_hit_r <= p1_hit_r;
      best_r   <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_dx_r  <= DX_W'(tx) - DX_W'(disk_radius);
    p1_dy_r  <= DX_W'(ty) - DX_W'(disk_radius);
    p2_out_r <= outside;
    p2_h_r   <= rdata;
  end

  assign best = best_r;

endmodule

/* design/tool_height_dilation_core.sv */
// ----------------------------------------------------------------------------
// Tool height dilation core
// Stores a signed Q8.8 height map and answers tool height queries by
// grayscale dilation with a flat disk cutter.
// ----------------------------------------------------------------------------
// A write word answers in the next cycle with tool height 0. A query
// inside the map walks the n x n window (n = window_cells, capped at
// MAX_WINDOW) one stored height per cycle through the single map read port,
// then passes the drain and done states; the done state waits for a free
// output slot. Off-map queries and zero-window queries answer as writes do.
// The input is not ready while a query walks. The height map is not
// cleared by reset; every cell a query reads must have been written first.
`include "tool_height_dilation_core_assert.svh"

module tool_height_dilation_core import thd_pkg::*; #(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [7:0]            in_col,
  input  logic [7:0]            in_row,
  input  logic [HEIGHT_W-1:0]   in_surface_height,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOOL_W-1:0]     out_tool_height,
  output logic                  out_in_map,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CRD_W  = $clog2(MAX_COLS + MAX_ROWS + 256 + 2 * MAX_WINDOW) + 1;
  localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          drain_r, drain_nxt;
  cfg_t                cfg_r, cfg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TOOL_W-1:0]   out_tool_r, out_tool_nxt;
  logic                out_map_r, out_map_nxt;

  logic [CRD_W-1:0]    w_eff, h_eff, col_x, row_x;
  logic [CNT_W-1:0]    n;
  logic                in_bounds, in_store, in_acc, slot_free, start;
  logic                ram_we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [HEIGHT_W-1:0] rdata;
  acc_ctl_t            ctl;
  logic [CNT_W-1:0]    tx, ty;
  logic                last;
  logic signed [HEIGHT_W-1:0] best;

  always_comb begin
    w_eff = (CRD_W'(cfg_r.map_width) > CRD_W'(MAX_COLS)) ?
            CRD_W'(MAX_COLS) : CRD_W'(cfg_r.map_width);
    h_eff = (CRD_W'(cfg_r.map_height) > CRD_W'(MAX_ROWS)) ?
            CRD_W'(MAX_ROWS) : CRD_W'(cfg_r.map_height);
    n     = (32'(cfg_r.window_cells) > 32'(MAX_WINDOW)) ?
            CNT_W'(MAX_WINDOW) : CNT_W'(cfg_r.window_cells);
    col_x     = CRD_W'(in_col);
    row_x     = CRD_W'(in_row);
    in_bounds = (col_x < w_eff) && (row_x < h_eff);
    in_store  = (col_x < CRD_W'(MAX_COLS)) && (row_x < CRD_W'(MAX_ROWS));
    waddr     = ADDR_W'(row_x[ROW_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(col_x[COL_W-1:0]);
  end

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:    cfg_nxt.map_width    = cfg_data[8:0];
        CFG_MAP_HEIGHT:   cfg_nxt.map_height   = cfg_data[8:0];
        CFG_WINDOW_CELLS: cfg_nxt.window_cells = cfg_data[5:0];
        CFG_DISK_RADIUS:  cfg_nxt.disk_radius  = cfg_data[RAD_W-1:0];
        CFG_DROP_DEPTH:   cfg_nxt.drop_depth   = cfg_data[14:0];
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  // sequencer and output word register
  always_comb begin
    slot_free     = !out_valid_r || out_ready;
    in_ready      = (state_r == ST_IDLE) && slot_free;
    in_acc        = in_valid && in_ready;
    start         = 1'b0;
    ram_we        = 1'b0;
    state_nxt     = state_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_tool_nxt  = out_tool_r;
    out_map_nxt   = out_map_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_WRITE) begin
            ram_we        = in_store;
            out_valid_nxt = 1'b1;
            out_tool_nxt  = '0;
            out_map_nxt   = in_bounds;
          end else if (!in_bounds || (n == '0)) begin
            out_valid_nxt = 1'b1;
            out_tool_nxt  = '0;
            out_map_nxt   = in_bounds;
          end else begin
            start     = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (last) begin
          drain_nxt = DRAIN_CYC;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_r == 2'd1) begin
          state_nxt = ST_DONE;
        end else begin
          drain_nxt = drain_r - 2'd1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_tool_nxt  = best[TOOL_W-1:0];
          out_map_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_r     <= '0;
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_r     <= drain_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tool_r <= out_tool_nxt;
    out_map_r  <= out_map_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tool_height = out_tool_r;
  assign out_in_map      = out_map_r;

  thd_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (MAX_COLS * MAX_ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_surface_height),
    .raddr (raddr),
    .rdata (rdata)
  );

  thd_seq #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .col   (in_col),
    .row   (in_row),
    .n     (n),
    .w_eff (w_eff),
    .h_eff (h_eff),
    .ctl   (ctl),
    .tx    (tx),
    .ty    (ty),
    .raddr (raddr),
    .last  (last)
  );

  thd_acc #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .tx          (tx),
    .ty          (ty),
    .disk_radius (cfg_r.disk_radius),
    .drop_depth  (cfg_r.drop_depth),
    .rdata       (rdata),
    .best        (best)
  );

  `THD_ASSERT(a_busy_no_ready, (state_r != ST_IDLE) |-> !in_ready, "input ready while busy")
  `THD_ASSERT_NEXT(a_write_resp, in_acc && (in_operation == OP_WRITE), out_valid && (out_tool_height == '0), "write word not answered with zero")
  `THD_ASSERT(a_outside_zero, (out_valid && !out_in_map) |-> (out_tool_height == '0), "nonzero height outside map")
  `THD_ASSERT(a_best_nonneg, !best[HEIGHT_W-1], "running maximum went negative")

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Tool height dilation core testbench
// A queue of pending words feeds a valid/ready driver, and a monitor predicts
// every accepted word and compares each result field with the oldest
// prediction. A short directed run covers extreme heights, writes and queries
// outside the map, a zero window, an oversized window and an oversized map.
// Random phases then follow, each with fresh register settings. Every cell
// that a query can read is written first. Both sides stall at random, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import thd_pkg::*;

  localparam int LIMIT_CYCLES = 10000000;
  localparam int HOLD_CYCLES  = 500;
  localparam int TOTAL_WORDS  = 1100;

  typedef struct packed {
    logic                op;
    logic [7:0]          col;
    logic [7:0]          row;
    logic [HEIGHT_W-1:0] height;
  } word_t;

  typedef struct packed {
    logic [TOOL_W-1:0] tool;
    logic              in_map;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = OP_WRITE;
  logic [7:0]            in_col = '0;
  logic [7:0]            in_row = '0;
  logic [HEIGHT_W-1:0]   in_surface_height = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TOOL_W-1:0]     out_tool_height;
  logic                  out_in_map;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  word_t           pending_words[$];
  result_t         heights_due[$];
  cfg_t            cfg_now = CFG_RESET;
  logic [HEIGHT_W-1:0] surface [0:65535];
  bit              cell_written [0:65535];
  int              words_queued = 0;
  int              words_in = 0;
  int              results_seen = 0;
  int              failures = 0;
  int              cycles = 0;
  int              send_gap, send_calm;
  int              take_gap, take_calm, hold_left;
  bit              hold_done;

  tool_height_dilation_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_col            (in_col),
    .in_row            (in_row),
    .in_surface_height (in_surface_height),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tool_height   (out_tool_height),
    .out_in_map        (out_in_map),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int map_cols();
    return (cfg_now.map_width > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cfg_now.map_width);
  endfunction

  function automatic int map_rows();
    return (cfg_now.map_height > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(cfg_now.map_height);
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MAP_WIDTH:    cfg_now.map_width    = data[8:0];
      CFG_MAP_HEIGHT:   cfg_now.map_height   = data[8:0];
      CFG_WINDOW_CELLS: cfg_now.window_cells = data[5:0];
      CFG_DISK_RADIUS:  cfg_now.disk_radius  = data[RAD_W-1:0];
      CFG_DROP_DEPTH:   cfg_now.drop_depth   = data[14:0];
      default: ;
    endcase
  endfunction

  // dilated height of one word; writes update the shadow map
  function automatic result_t cut_height(input word_t wd);
    result_t res;
    int w, h, n, c, r, best, nx, ny, dx, dy, v;
    w = map_cols();
    h = map_rows();
    n = (cfg_now.window_cells > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(cfg_now.window_cells);
    c = n / 2;
    r = int'(cfg_now.disk_radius);
    res.in_map = (int'(wd.col) < w) && (int'(wd.row) < h);
    res.tool = '0;
    if (wd.op == OP_WRITE) begin
      surface[{wd.row, wd.col}] = wd.height;
    end else if (res.in_map) begin
      best = 0;
      for (int tx = 0; tx < n; tx++) begin
        nx = int'(wd.col) - tx + c;
        if (nx < 0 || nx >= w) continue;
        for (int ty = 0; ty < n; ty++) begin
          ny = int'(wd.row) - ty + c;
          if (ny < 0 || ny >= h) continue;
          v = int'($signed(surface[ny * MAX_COLS_DEF + nx]));
          dx = tx - r;
          dy = ty - r;
          if (dx * dx + dy * dy > r * r) v -= int'(cfg_now.drop_depth);
          if (v > best) best = v;
        end
      end
      res.tool = best[TOOL_W-1:0];
    end
    return res;
  endfunction

  task automatic note_miss(input string what, input int want, input int got);
    failures++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  // driver
  always @(posedge clk) begin : drive
    word_t wd;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_gap  <= 0;
      send_calm <= 0;
    end else begin
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_words.size() != 0) begin
          wd = pending_words.pop_front();
          in_valid          <= 1'b1;
          in_operation      <= wd.op;
          in_col            <= wd.col;
          in_row            <= wd.row;
          in_surface_height <= wd.height;
          send_gap          <= (send_calm != 0) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (send_calm != 0) send_calm <= send_calm - 1;
      else if ($urandom_range(0, 299) == 0) send_calm <= $urandom_range(50, 400);
    end
  end

  // result side, with one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      take_gap  <= 0;
      take_calm <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && words_in > 60 && pending_words.size() > 30) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (take_gap != 0) begin
        out_ready <= 1'b0;
        take_gap  <= take_gap - 1;
      end else begin
        out_ready <= 1'b1;
        take_gap  <= (take_calm != 0) ? 0 : pick_gap();
      end
      if (take_calm != 0) take_calm <= take_calm - 1;
      else if ($urandom_range(0, 299) == 0) take_calm <= $urandom_range(50, 400);
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    word_t   wd;
    result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        wd.op     = in_operation;
        wd.col    = in_col;
        wd.row    = in_row;
        wd.height = in_surface_height;
        heights_due.insert(heights_due.size(), cut_height(wd));
        words_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (heights_due.size() == 0) begin
          note_miss("result word (none pending), tool_height", -1, int'(out_tool_height));
        end else begin
          want = heights_due.pop_front();
          if (want.tool !== out_tool_height)
            note_miss("tool_height", int'(want.tool), int'(out_tool_height));
          if (want.in_map !== out_in_map)
            note_miss("in_map", int'(want.in_map), int'(out_in_map));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_word(input logic op, input int col, input int row,
                            input logic [HEIGHT_W-1:0] height);
    word_t wd;
    wd.op     = op;
    wd.col    = 8'(col);
    wd.row    = 8'(row);
    wd.height = height;
    pending_words.insert(pending_words.size(), wd);
    words_queued++;
    if (op == OP_WRITE) cell_written[{wd.row, wd.col}] = 1'b1;
  endtask

  function automatic logic [HEIGHT_W-1:0] rand_height();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return 16'h8000;
    if (p < 16) return 16'h7FFF;
    if (p < 60) return HEIGHT_W'($urandom_range(0, 16'h1000));
    return HEIGHT_W'($urandom);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    store_reg(idx, data);
  endtask

  // registers change only once every word has been answered
  task automatic set_config(input int w, input int h, input int n, input int r, input int drop);
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_IDX_W-1:0]  spare_idx;
    while (results_seen != words_queued) @(posedge clk);
    repeat (4) @(posedge clk);
    data = CFG_DATA_W'($urandom); data[8:0] = w[8:0];
    write_reg(CFG_MAP_WIDTH, data);
    data = CFG_DATA_W'($urandom); data[8:0] = h[8:0];
    write_reg(CFG_MAP_HEIGHT, data);
    data = CFG_DATA_W'($urandom); data[5:0] = n[5:0];
    write_reg(CFG_WINDOW_CELLS, data);
    data = CFG_DATA_W'($urandom); data[RAD_W-1:0] = r[RAD_W-1:0];
    write_reg(CFG_DISK_RADIUS, data);
    write_reg(CFG_DROP_DEPTH, drop[14:0]);
    // unmapped index must leave everything alone
    spare_idx = CFG_IDX_W'($urandom_range(int'(CFG_DROP_DEPTH) + 1, (1 << CFG_IDX_W) - 1));
    data = CFG_DATA_W'($urandom);
    write_reg(spare_idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_map();
    for (int r = 0; r < map_rows(); r++)
      for (int c = 0; c < map_cols(); c++)
        if (!cell_written[r * MAX_COLS_DEF + c]) queue_word(OP_WRITE, c, r, rand_height());
  endtask

  task automatic random_word();
    logic op;
    int   col, row;
    op = ($urandom_range(0, 9) < 6) ? OP_QUERY : OP_WRITE;
    if ($urandom_range(0, 99) < ((op == OP_QUERY) ? 85 : 70)) begin
      col = $urandom_range(0, map_cols() - 1);
      row = $urandom_range(0, map_rows() - 1);
    end else begin
      col = $urandom_range(0, 255);
      row = $urandom_range(0, 255);
    end
    queue_word(op, col, row, (op == OP_QUERY) ? HEIGHT_W'($urandom) : rand_height());
  endtask

  initial begin : stimulus
    int phase, kind, w, h, n, r, drop, n_eff, count, q;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 map with extreme heights, then corner, centre and off-map queries
    set_config(3, 3, 7, 3, 2560);
    queue_word(OP_WRITE, 0, 0, 16'h7FFF);
    queue_word(OP_WRITE, 1, 0, 16'h8000);
    queue_word(OP_WRITE, 2, 0, 16'h0100);
    queue_word(OP_WRITE, 0, 1, 16'hFFFF);
    queue_word(OP_WRITE, 1, 1, 16'h0000);
    queue_word(OP_WRITE, 2, 1, 16'h0A00);
    queue_word(OP_WRITE, 0, 2, 16'h1234);
    queue_word(OP_WRITE, 1, 2, 16'h7F00);
    queue_word(OP_WRITE, 2, 2, 16'h8001);
    queue_word(OP_WRITE, 255, 255, 16'h5A5A);
    queue_word(OP_QUERY, 1, 1, 16'h0000);
    queue_word(OP_QUERY, 0, 0, 16'hFFFF);
    queue_word(OP_QUERY, 2, 2, 16'h0000);
    queue_word(OP_QUERY, 0, 2, 16'h0000);
    queue_word(OP_QUERY, 3, 0, 16'h0000);
    queue_word(OP_QUERY, 0, 3, 16'h0000);
    queue_word(OP_QUERY, 255, 255, 16'h0000);

    // empty window
    set_config(3, 3, 0, 3, 2560);
    queue_word(OP_QUERY, 1, 1, 16'h0000);
    queue_word(OP_QUERY, 0, 0, 16'h0000);

    // window beyond the cap, widest disk, no drop
    set_config(3, 3, 63, 31, 0);
    queue_word(OP_QUERY, 1, 1, 16'h0000);

    // width beyond the cap, single row, deepest drop
    set_config(511, 1, 1, 0, 32767);
    fill_map();
    queue_word(OP_QUERY, 255, 0, 16'h0000);
    queue_word(OP_QUERY, 0, 1, 16'h0000);

    phase = 0;
    while (words_queued < TOTAL_WORDS) begin
      kind = phase % 10;
      case (kind)
        5:       begin w = $urandom_range(256, 511); h = $urandom_range(1, 2); end
        6:       begin w = $urandom_range(1, 2); h = $urandom_range(256, 511); end
        7:       begin w = 1; h = 1; end
        8:       begin w = 256; h = 2; end
        9:       begin w = $urandom_range(13, 24); h = $urandom_range(13, 24); end
        default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
      endcase
      q = $urandom_range(0, 19);
      if (q == 0) n = 0;
      else if (q == 1) n = $urandom_range(33, 63);
      else if (q == 2) n = MAX_WINDOW_DEF;
      else if (q <= 4) n = $urandom_range(10, 20);
      else n = $urandom_range(1, 9);
      n_eff = (n > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : n;
      if ($urandom_range(0, 1) == 0) r = $urandom_range(0, 31);
      else r = $urandom_range(0, (n_eff / 2 + 1 > 31) ? 31 : n_eff / 2 + 1);
      q = $urandom_range(0, 9);
      drop = (q == 0) ? 0 : (q == 1) ? 32767 : $urandom_range(0, 32767);
      set_config(w, h, n, r, drop);
      fill_map();
      count = (n_eff >= 16) ? 6 : (n_eff >= 10) ? 30 : 80;
      repeat (count) random_word();
      phase++;
    end

    while (results_seen != words_queued) @(posedge clk);
    repeat (64) @(posedge clk);
    if (heights_due.size() != 0) begin
      failures++;
      $display("%0t: %0d results never arrived", $time, heights_due.size());
    end
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/thd_pkg.sv
design/thd_ram.sv
design/thd_seq.sv
design/thd_acc.sv
design/tool_height_dilation_core.sv
test/tb.sv
